### hdl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranging unit
// Phase and status codes, register indexes, field widths and the constants
// of the reciprocal multiply that forms the mean distance.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  // Number of echoes averaged per measurement (1..8).
  localparam int unsigned SAMPLES = 5;

  localparam int unsigned TRIG_W    = 10;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned SUM_W     = 20;
  localparam int unsigned DIST_W    = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Mean in 1/16 cm: floor(sum * 16 / (58 * SAMPLES)).
  // Exact reciprocal: for x < 2^SCALED_W, floor(x / DIV) equals
  // (x * RECIP) >> RECIP_SHIFT with RECIP = ceil(2^RECIP_SHIFT / DIV).
  localparam int unsigned DIV         = 58 * SAMPLES;
  localparam int unsigned DIV_LOG     = $clog2(DIV);
  localparam int unsigned SCALED_W    = SUM_W + 4;
  localparam int unsigned RECIP_SHIFT = SCALED_W + DIV_LOG;
  localparam int unsigned RECIP_W     = SCALED_W + 1;
  localparam int unsigned PROD_W      = SCALED_W + RECIP_W;
  // Product bits above the shift; wide enough for the largest quotient.
  localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV));
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_RISE = 4'b0100,
    PH_HIGH = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_RISE  = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_UNUSED   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIG_WIDTH   = 2'd0,
    CFG_RISE_TIMEOUT = 2'd1,
    CFG_ECHO_TIMEOUT = 2'd2,
    CFG_NONE         = 2'd3
  } cfg_idx_e;

  // Result flags carried from the control stage to the output stage.
  typedef struct packed {
    logic    trigger;
    logic    done;
    status_e status;
    logic    busy;
  } res_flags_t;

endpackage

`default_nettype wire

### hdl/uer_mean_div.sv
// ----------------------------------------------------------------------------
// uer_mean_div: mean distance stage
// Divides the echo sum by 58*SAMPLES/16 through a reciprocal multiply,
// saturates to the field range, gives zero unless ok_i is set, and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_mean_div (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic                          ok_i,
  input  wire logic [uer_pkg::SUM_W-1:0]     sum_i,
  output logic      [uer_pkg::DIST_W-1:0]    dist_o
);

  logic [uer_pkg::SCALED_W-1:0] scaled;
  logic [uer_pkg::PROD_W-1:0]   prod;
  logic [uer_pkg::QUOT_W-1:0]   quot;
  logic [uer_pkg::DIST_W-1:0]   dist_d, dist_q;

  assign scaled = {sum_i, 4'b0000};
  assign prod   = uer_pkg::PROD_W'(scaled) * uer_pkg::PROD_W'(uer_pkg::RECIP);
  assign quot   = prod[uer_pkg::RECIP_SHIFT +: uer_pkg::QUOT_W];

  always_comb begin
    if (!ok_i) begin
      dist_d = '0;
    end else if (quot > uer_pkg::QUOT_W'(uer_pkg::DIST_MAX)) begin
      dist_d = uer_pkg::DIST_MAX;
    end else begin
      dist_d = quot[uer_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;

endmodule

`default_nettype wire

### hdl/ultrasonic_echo_ranging_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranging_unit: averaged ultrasonic range controller
// Trigger pulse, echo rise wait and echo width count per microsecond tick,
// averaged over SAMPLES echoes, reported as distance in 1/16 cm.
// ----------------------------------------------------------------------------
// Each request on the input stream is one microsecond tick carrying start_req
// and the sampled echo level; each tick produces exactly one result with the
// trigger drive, done flag, status, distance and busy flag. The unit takes a
// new tick every cycle while not stalled: the control state (phase, tick
// counter, sample count, echo sum) advances in the cycle a tick is accepted,
// and the result leaves through a flag stage and an output stage that holds
// the reciprocal multiply for the mean. Both stages move together under one
// enable, so a stalled output holds the input off and nothing is dropped.
// A measurement: start in idle drives the trigger for trigger_width ticks
// (zero acts as one), waits up to rise_timeout low ticks for the echo
// (status 1 on timeout), counts the echo high time up to echo_timeout
// (status 2 if exceeded), repeats SAMPLES times and reports
// floor(sum*16/(58*SAMPLES)) saturated to 32767. start_req is ignored while
// busy. Configuration writes are always taken (cfg_ready_o is tied high) and
// should only be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranging_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input ticks
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] start_req, [1] echo, rest zero
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [0] trigger, [1] done_res,
                                           // [3:2] status, [18:4] distance,
                                           // [19] busy_res, rest zero
  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [uer_pkg::CFG_DAT_W-1:0] cfg_data_i
);

  // ---- configuration registers ----
  logic [uer_pkg::TRIG_W-1:0]    trig_width_q;
  logic [uer_pkg::TIMEOUT_W-1:0] rise_timeout_q;
  logic [uer_pkg::TIMEOUT_W-1:0] echo_timeout_q;
  uer_pkg::cfg_idx_e             cfg_idx;

  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = uer_pkg::cfg_idx_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_width_q   <= uer_pkg::TRIG_W'(30);
      rise_timeout_q <= uer_pkg::TIMEOUT_W'(5000);
      echo_timeout_q <= uer_pkg::TIMEOUT_W'(23530);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx)
        uer_pkg::CFG_TRIG_WIDTH:   trig_width_q   <= cfg_data_i[uer_pkg::TRIG_W-1:0];
        uer_pkg::CFG_RISE_TIMEOUT: rise_timeout_q <= cfg_data_i;
        uer_pkg::CFG_ECHO_TIMEOUT: echo_timeout_q <= cfg_data_i;
        default: ;  // index out of range: ignored
      endcase
    end
  end

  // ---- pipeline enable: both stages advance together ----
  logic en;
  logic accept;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  // ---- control state ----
  uer_pkg::phase_e                phase_q, phase_d;
  logic [uer_pkg::ELAPSED_W-1:0]  elapsed_q, elapsed_d;
  logic [uer_pkg::COUNT_W-1:0]    count_q, count_d;
  logic [uer_pkg::SUM_W-1:0]      sum_q, sum_d;
  uer_pkg::res_flags_t            flags;

  logic start, echo;
  logic is_idle;
  logic [uer_pkg::ELAPSED_W-1:0] trig_cnt;
  logic [uer_pkg::SUM_W-1:0]     sum_add;
  logic [uer_pkg::COUNT_W-1:0]   count_inc;

  assign start   = s_axis_tdata[0];
  assign echo    = s_axis_tdata[1];
  // unused phase codes act as idle
  assign is_idle = !(phase_q == uer_pkg::PH_TRIG || phase_q == uer_pkg::PH_RISE ||
                     phase_q == uer_pkg::PH_HIGH);

  // the start tick is already the first trigger tick
  assign trig_cnt  = (is_idle ? '0 : elapsed_q) + uer_pkg::ELAPSED_W'(1);
  assign sum_add   = sum_q + uer_pkg::SUM_W'(elapsed_q);
  assign count_inc = count_q + uer_pkg::COUNT_W'(1);

  always_comb begin
    phase_d       = phase_q;
    elapsed_d     = elapsed_q;
    count_d       = count_q;
    sum_d         = sum_q;
    flags.trigger = 1'b0;
    flags.done    = 1'b0;
    flags.status  = uer_pkg::ST_OK;
    flags.busy    = 1'b1;

    priority if (is_idle && !start) begin
      phase_d    = uer_pkg::PH_IDLE;
      flags.busy = 1'b0;
    end else if (is_idle || phase_q == uer_pkg::PH_TRIG) begin
      flags.trigger = 1'b1;
      if (is_idle) begin
        count_d = '0;
        sum_d   = '0;
      end
      if (trig_cnt >= uer_pkg::ELAPSED_W'(trig_width_q)) begin
        phase_d   = uer_pkg::PH_RISE;
        elapsed_d = '0;
      end else begin
        phase_d   = uer_pkg::PH_TRIG;
        elapsed_d = trig_cnt;
      end
    end else if (phase_q == uer_pkg::PH_RISE) begin
      if (echo) begin
        phase_d   = uer_pkg::PH_HIGH;
        elapsed_d = uer_pkg::ELAPSED_W'(1);
      end else if (elapsed_q >= rise_timeout_q) begin
        phase_d      = uer_pkg::PH_IDLE;
        elapsed_d    = '0;
        flags.done   = 1'b1;
        flags.status = uer_pkg::ST_NO_RISE;
        flags.busy   = 1'b0;
      end else begin
        elapsed_d = elapsed_q + uer_pkg::ELAPSED_W'(1);
      end
    end else begin
      // echo high: count, or close the sample on the falling edge
      if (echo) begin
        if (elapsed_q >= echo_timeout_q && elapsed_q != '0) begin
          phase_d      = uer_pkg::PH_IDLE;
          elapsed_d    = '0;
          flags.done   = 1'b1;
          flags.status = uer_pkg::ST_TOO_LONG;
          flags.busy   = 1'b0;
        end else begin
          elapsed_d = elapsed_q + uer_pkg::ELAPSED_W'(1);
        end
      end else begin
        sum_d     = sum_add;
        count_d   = count_inc;
        elapsed_d = '0;
        if (count_inc >= uer_pkg::COUNT_W'(uer_pkg::SAMPLES)) begin
          phase_d    = uer_pkg::PH_IDLE;
          flags.done = 1'b1;
          flags.busy = 1'b0;
        end else begin
          phase_d = uer_pkg::PH_TRIG;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= uer_pkg::PH_IDLE;
      elapsed_q <= '0;
      count_q   <= '0;
      sum_q     <= '0;
    end else if (accept) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
    end
  end

  // ---- stage 1: flags and final sum ----
  logic                       valid1_q;
  uer_pkg::res_flags_t        flags1_q;
  logic                       ok1_q;
  logic [uer_pkg::SUM_W-1:0]  sum1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else if (en) begin
      valid1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flags1_q <= flags;
      ok1_q    <= flags.done && (flags.status == uer_pkg::ST_OK);
      sum1_q   <= sum_d;
    end
  end

  // ---- stage 2: output register, mean divide ----
  uer_pkg::res_flags_t         flags2_q;
  logic [uer_pkg::DIST_W-1:0]  mean_dist;

  uer_mean_div u_mean_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .ok_i   (ok1_q),
    .sum_i  (sum1_q),
    .dist_o (mean_dist)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flags2_q <= flags1_q;
    end
  end

  assign m_axis_tdata = {4'b0000, flags2_q.busy, mean_dist, flags2_q.status,
                         flags2_q.done, flags2_q.trigger};

endmodule

`default_nettype wire

### verif/tb_ultrasonic_echo_ranging_unit.sv
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranging_unit: self-checking bench of the ranging unit
// Streams microsecond ticks into the unit with random gaps and output stalls.
// A cycle-true predictor of the trigger/rise/echo sequencer works out the
// result of every accepted tick, and each result leaving the unit is
// compared field by field against the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ultrasonic_echo_ranging_unit;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned RANDOM_TICKS = 300;

  // One expected result of one tick
  typedef struct packed {
    logic                          trigger;
    logic                          done;
    uer_pkg::status_e              status;
    logic [uer_pkg::DIST_W-1:0]    distance;
    logic                          busy;
  } range_res_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of registers and sequencer state, plus the queue of
  // results still owed by the unit.
  // --------------------------------------------------------------------------
  class echo_range_scoreboard;
    logic [uer_pkg::TRIG_W-1:0]    trig_width;
    logic [uer_pkg::TIMEOUT_W-1:0] rise_limit;
    logic [uer_pkg::TIMEOUT_W-1:0] echo_limit;
    uer_pkg::phase_e               phase;
    logic [uer_pkg::ELAPSED_W-1:0] elapsed;
    logic [uer_pkg::COUNT_W-1:0]   samples_done;
    logic [uer_pkg::SUM_W-1:0]     echo_sum;
    range_res_t                    expected_q[$];
    int unsigned                   fails;

    function new();
      trig_width   = 10'd30;
      rise_limit   = 16'd5000;
      echo_limit   = 16'd23530;
      phase        = uer_pkg::PH_IDLE;
      elapsed      = '0;
      samples_done = '0;
      echo_sum     = '0;
      fails        = 0;
    endfunction

    function void write_reg(uer_pkg::cfg_idx_e idx, logic [uer_pkg::CFG_DAT_W-1:0] val);
      case (idx)
        uer_pkg::CFG_TRIG_WIDTH:   trig_width = val[uer_pkg::TRIG_W-1:0];
        uer_pkg::CFG_RISE_TIMEOUT: rise_limit = val;
        uer_pkg::CFG_ECHO_TIMEOUT: echo_limit = val;
        default: ;
      endcase
    endfunction

    // Advance the sequencer by one accepted tick and queue its result
    function void note_tick(bit start, bit echo);
      range_res_t res;
      logic [63:0] mean;
      res = '{trigger: 1'b0, done: 1'b0, status: uer_pkg::ST_OK,
              distance: '0, busy: 1'b1};

      if (phase == uer_pkg::PH_IDLE) begin
        if (start) begin
          phase        = uer_pkg::PH_TRIG;
          elapsed      = '0;
          samples_done = '0;
          echo_sum     = '0;
        end else begin
          res.busy = 1'b0;
        end
      end

      case (phase)
        uer_pkg::PH_TRIG: begin
          res.trigger = 1'b1;
          elapsed = elapsed + 1'b1;
          // width zero still gives one trigger tick
          if (elapsed >= uer_pkg::ELAPSED_W'(trig_width)) begin
            phase   = uer_pkg::PH_RISE;
            elapsed = '0;
          end
        end
        uer_pkg::PH_RISE: begin
          if (echo) begin
            // rising tick is the first counted echo tick
            phase   = uer_pkg::PH_HIGH;
            elapsed = 16'd1;
          end else if (elapsed >= rise_limit) begin
            phase      = uer_pkg::PH_IDLE;
            elapsed    = '0;
            res.done   = 1'b1;
            res.status = uer_pkg::ST_NO_RISE;
            res.busy   = 1'b0;
          end else begin
            elapsed = elapsed + 1'b1;
          end
        end
        uer_pkg::PH_HIGH: begin
          if (echo) begin
            if (elapsed >= echo_limit && elapsed >= 16'd1) begin
              phase      = uer_pkg::PH_IDLE;
              elapsed    = '0;
              res.done   = 1'b1;
              res.status = uer_pkg::ST_TOO_LONG;
              res.busy   = 1'b0;
            end else begin
              elapsed = elapsed + 1'b1;
            end
          end else begin
            echo_sum     = echo_sum + uer_pkg::SUM_W'(elapsed);
            samples_done = samples_done + 1'b1;
            elapsed      = '0;
            if (samples_done >= uer_pkg::COUNT_W'(uer_pkg::SAMPLES)) begin
              phase    = uer_pkg::PH_IDLE;
              res.done = 1'b1;
              res.busy = 1'b0;
              mean = (64'(echo_sum) * 64'd16) / (64'd58 * 64'(uer_pkg::SAMPLES));
              res.distance = (mean > 64'(uer_pkg::DIST_MAX)) ?
                             uer_pkg::DIST_MAX : mean[uer_pkg::DIST_W-1:0];
            end else begin
              phase = uer_pkg::PH_TRIG;
            end
          end
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [23:0] data);
      range_res_t want;
      if (expected_q.size() == 0) begin
        $error("result %h arrived with no tick outstanding", data);
        fails++;
        return;
      end
      want = expected_q.pop_front();
      if (data[0] !== want.trigger) begin
        $error("trigger: expected %0d, got %0d", want.trigger, data[0]);
        fails++;
      end
      if (data[1] !== want.done) begin
        $error("done_res: expected %0d, got %0d", want.done, data[1]);
        fails++;
      end
      if (data[3:2] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, data[3:2]);
        fails++;
      end
      if (data[18:4] !== want.distance) begin
        $error("distance: expected %0d, got %0d", want.distance, data[18:4]);
        fails++;
      end
      if (data[19] !== want.busy) begin
        $error("busy_res: expected %0d, got %0d", want.busy, data[19]);
        fails++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          s_tvalid    = 1'b0;
  logic [7:0]                    s_tdata     = '0;
  logic                          m_tready    = 1'b0;
  logic                          cfg_valid   = 1'b0;
  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
  logic [uer_pkg::CFG_DAT_W-1:0] cfg_data    = '0;
  wire                           s_tready;
  wire                           m_tvalid;
  wire  [23:0]                   m_tdata;
  wire                           cfg_ready;

  echo_range_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned ticks_sent  = 0;
  int unsigned ready_hold  = 0;
  bit          no_idle     = 1'b0;   // set for stretches run at full rate

  ultrasonic_echo_ranging_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Low ticks before the echo rises: sometimes right at the timeout or one
  // past it (abort), mostly a few
  function automatic int unsigned pick_low();
    int unsigned lim;
    lim = sb.rise_limit;
    case ($urandom_range(0, 7))
      0: if (lim <= 64) return lim + 1;
      1: if (lim <= 64) return lim;
      default: ;
    endcase
    return $urandom_range(0, (lim < 6) ? lim : 6);
  endfunction

  // High ticks including the rising one: boundary, one past it, or short
  function automatic int unsigned pick_high();
    int unsigned lim;
    lim = (sb.echo_limit == 0) ? 1 : sb.echo_limit;
    case ($urandom_range(0, 7))
      0: if (lim <= 64) return lim + 1;
      1: if (lim <= 300) return lim;
      2: return $urandom_range(1, (lim < 100) ? lim : 100);
      default: ;
    endcase
    return $urandom_range(1, (lim < 10) ? lim : 10);
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stalls, result check on every accepted request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic nxt_ready;
    nxt_ready = m_tready;
    if (rst_ni && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (no_idle || $urandom_range(0, 1)) begin
      nxt_ready  = 1'b1;
      ready_hold = $urandom_range(0, 20);
    end else begin
      nxt_ready  = 1'b0;
      ready_hold = pick_gap();
    end
    m_tready <= nxt_ready;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // One tick request; returns at the edge it is accepted
  task automatic send_tick(bit start, bit echo);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, echo, start};
    do @(posedge clk_i); while (!s_tready);
    sb.note_tick(start, echo);
    ticks_sent++;
  endtask

  // Keep ticking with no start until the sequencer is back in idle
  task automatic drain_to_idle();
    while (sb.phase != uer_pkg::PH_IDLE) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  // Idle the unit fully before a register write
  task automatic settle();
    drain_to_idle();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Back-to-back writes of all three registers, optionally preceded by a
  // write to the unused index (must be ignored)
  task automatic set_regs(logic [uer_pkg::CFG_DAT_W-1:0] tw,
                          logic [uer_pkg::CFG_DAT_W-1:0] rise,
                          logic [uer_pkg::CFG_DAT_W-1:0] echo_lim, bit with_none);
    uer_pkg::cfg_idx_e               idx[4];
    logic [uer_pkg::CFG_DAT_W-1:0]   val[4];
    idx = '{uer_pkg::CFG_NONE, uer_pkg::CFG_TRIG_WIDTH, uer_pkg::CFG_RISE_TIMEOUT,
            uer_pkg::CFG_ECHO_TIMEOUT};
    val = '{uer_pkg::CFG_DAT_W'($urandom()), tw, rise, echo_lim};
    for (int i = with_none ? 0 : 1; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk_i); while (!cfg_ready);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // One well-formed averaged measurement with random echo timing. Start
  // requests are thrown in at random while busy; they must be ignored.
  task automatic run_measurement();
    int unsigned lows, highs;
    lows  = pick_low();
    highs = pick_high();
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    while (sb.phase != uer_pkg::PH_IDLE) begin
      case (sb.phase)
        uer_pkg::PH_TRIG: begin
          // echo level is don't-care while triggering
          lows  = pick_low();
          highs = pick_high();
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        uer_pkg::PH_RISE: begin
          if (lows > 0) begin
            lows--;
            send_tick(1'($urandom_range(0, 1)), 1'b0);
          end else begin
            highs--;
            send_tick(1'($urandom_range(0, 1)), 1'b1);
          end
        end
        uer_pkg::PH_HIGH: begin
          if (highs > 0) begin
            highs--;
            send_tick(1'($urandom_range(0, 1)), 1'b1);
          end else begin
            send_tick(1'($urandom_range(0, 1)), 1'b0);
          end
        end
        default: send_tick(1'b0, 1'b0);
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned base;
    logic [uer_pkg::CFG_DAT_W-1:0] tw, rise, echo_lim;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values
    run_measurement();

    // Zero trigger width (upper data bits set, must be masked), zero timeouts
    settle();
    set_regs(16'hFC00, 16'd0, 16'd0, 1'b1);
    for (int i = 0; i < uer_pkg::SAMPLES; i++) begin
      send_tick(1'b1, 1'b1);   // trigger tick, start ignored once busy
      send_tick(1'b1, 1'b1);   // rise
      send_tick(1'b1, 1'b0);   // fall after a single echo tick
    end
    // echo too long with zero echo timeout
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    // echo never rises with zero rise timeout
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);

    // Widest trigger pulse, then no echo so the measurement aborts early
    settle();
    set_regs(16'd1023, 16'd1, 16'hFFFF, 1'b0);
    send_tick(1'b1, 1'b0);
    while (sb.phase != uer_pkg::PH_IDLE) send_tick(1'b0, 1'b0);

    // Largest timeouts
    settle();
    set_regs(16'd1, 16'hFFFF, 16'hFFFF, 1'b1);
    repeat (2) run_measurement();

    // Random settings, mostly short timing so many measurements complete
    base = ticks_sent;
    while (ticks_sent - base < RANDOM_TICKS) begin
      settle();
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0:       tw = 16'd0;
        1:       tw = 16'($urandom_range(5, 40));
        2:       tw = (16'($urandom()) | 16'hFC00) & 16'hFC03;
        default: tw = 16'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 7))
        0:       rise = 16'd0;
        1:       rise = 16'($urandom());
        default: rise = 16'($urandom_range(1, 10));
      endcase
      case ($urandom_range(0, 7))
        0:       echo_lim = 16'd0;
        1:       echo_lim = 16'($urandom());
        2:       echo_lim = 16'($urandom_range(20, 300));
        default: echo_lim = 16'($urandom_range(1, 12));
      endcase
      set_regs(tw, rise, echo_lim, $urandom_range(0, 7) == 0);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: random pin levels with rare start requests
          repeat ($urandom_range(5, 30))
            send_tick($urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)));
          drain_to_idle();
        end else begin
          run_measurement();
        end
      end
    end
    no_idle = 1'b0;

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.fails == 0 && sb.expected_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hdl/uer_pkg.sv
hdl/uer_mean_div.sv
hdl/ultrasonic_echo_ranging_unit.sv
verif/tb_ultrasonic_echo_ranging_unit.sv
